[src/spdv_pkg.sv]
// Shared types, constants and saturation helpers for the spring-damper velocity update.
package spdv_pkg;

   localparam int REQ_W      = 272;
   localparam int RSP_W      = 128;
   localparam int CSR_ADDR_W = 2;
   localparam int DT_BITS    = 16;

   // Internal values are clipped to a 48 bit signed range of +-(2^47-1).
   localparam logic [46:0] LIM = {47{1'b1}};

   localparam logic [CSR_ADDR_W-1:0] CSR_STIFFNESS    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_REST_LENGTH  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DAMPING_GAIN = 2'd2;

   typedef struct packed {
      logic signed [31:0] stiffness;
      logic [30:0]        rest_length;
      logic [30:0]        damping_gain;
   } cfg_type;

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [31:0] va_x;
      logic signed [31:0] va_y;
      logic signed [31:0] vb_x;
      logic signed [31:0] vb_y;
      logic [15:0]        dt;
   } front_type;

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [32:0]        mag_x;
      logic [32:0]        mag_y;
      logic               neg_x;
      logic               neg_y;
      logic signed [48:0] va_x;
      logic signed [48:0] va_y;
      logic signed [48:0] vb_x;
      logic signed [48:0] vb_y;
      logic [31:0]        k_mag;
      logic               k_neg;
      logic [65:0]        len2;
      logic               nz;
      logic [32:0]        root;
      logic signed [34:0] diff;
      logic [80:0]        pa;
      logic [80:0]        pb;
      logic [80:0]        pc;
      logic [80:0]        pd;
      logic [46:0]        m_mag;
      logic               m_neg;
      logic signed [47:0] vd_x;
      logic signed [47:0] vd_y;
      logic signed [47:0] rx;
      logic signed [47:0] ry;
      logic               n1;
      logic               n2;
      logic [79:0]        t1;
      logic [79:0]        t2;
      logic [79:0]        dm;
      logic               dneg;
      logic [110:0]       num;
      logic [112:0]       rem;
      logic [46:0]        quo;
      logic               ovf;
      logic [46:0]        c_mag;
      logic               c_neg;
      logic               sat;
   } work_type;

   // Clips an unsigned magnitude to LIM; the top bit of the result is the clip flag.
   function automatic logic [47:0] clip_mag(input logic [127:0] v);
      if (|v[127:47]) begin
         return {1'b1, LIM};
      end
      return {1'b0, v[46:0]};
   endfunction

   // Clips a signed value to +-LIM; the top bit of the result is the clip flag.
   function automatic logic [48:0] clip_sgn(input logic signed [63:0] v);
      logic signed [63:0] lim;
      lim = {17'b0, LIM};
      if (v > lim) begin
         return {1'b1, 1'b0, LIM};
      end else if (v < -lim) begin
         return {1'b1, 1'b1, 46'b0, 1'b1};
      end
      return {1'b0, v[47:0]};
   endfunction

   // Clips a signed value to 32 bits; the top bit of the result is the clip flag.
   function automatic logic [32:0] clip_out(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return {1'b1, 32'h7FFF_FFFF};
      end else if (v < -64'sd2147483648) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, v[31:0]};
   endfunction

endpackage

[src/spring_damper_velocity_update.sv]
// Top level of the spring-damper velocity update: register port, front, queue and back.
//
// Usage: each request on the req_ stream carries two particle positions, their
// velocities and a time step; each one yields exactly one response on the rsp_
// stream with both updated velocities (tdata) and a saturation flag (tuser).
// Responses leave in request order. The csr_ port writes stiffness, rest length
// and damping gain; write it only while no request is in flight.
// Throughput: one request per cycle while the output is not stalled, set by the
// fully pipelined back part (33 square-root stages, 47 divider stages,
// multipliers split into registered partial products).
// Stalls: while rsp_tready is low with a response waiting, the whole back
// pipeline holds; the front keeps taking requests until the queue of
// QUEUE_DEPTH entries fills, and only then drops req_tready.
// Reset (synchronous, active high) empties the queue and the pipeline and loads
// stiffness 1.0, rest length 1.0 and damping gain 0.5.
module spring_damper_velocity_update #(
   parameter int FRAC_BITS   = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y, time_step
   input  logic [spdv_pkg::REQ_W-1:0]            req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
   output logic [spdv_pkg::RSP_W-1:0]            rsp_tdata,
   // saturated
   output logic                                  rsp_tuser,
   input  logic                                  csr_we,
   input  logic [spdv_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [31:0]                           csr_wdata
);
   import spdv_pkg::*;

   cfg_type   cfg_ff;
   front_type push_data, pop_data;
   logic      push, pop, queue_full, queue_empty;

   // Register writes; an index beyond the three registers is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stiffness    <= 32'sd65536;
         cfg_ff.rest_length  <= 31'd65536;
         cfg_ff.damping_gain <= 31'd32768;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_STIFFNESS: begin
               cfg_ff.stiffness <= csr_wdata;
            end
            CSR_REST_LENGTH: begin
               cfg_ff.rest_length <= csr_wdata[30:0];
            end
            CSR_DAMPING_GAIN: begin
               cfg_ff.damping_gain <= csr_wdata[30:0];
            end
            default: begin
            end
         endcase
      end
   end

   spdv_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // The queue lets the front keep accepting while the back is held up.
   spdv_fifo #(
      .WIDTH ($bits(front_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (push_data),
      .full    (queue_full),
      .rd_en   (pop),
      .rd_data (pop_data),
      .empty   (queue_empty)
   );

   spdv_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (!queue_empty),
      .in_data    (pop_data),
      .in_pop     (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[src/spdv_fifo.sv]
// Small register-based first-in first-out queue between the front and back parts.
module spdv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW:0]      wptr_ff, wptr_in;
   logic [AW:0]      rptr_ff, rptr_in;

   assign empty   = (wptr_ff == rptr_ff);
   assign full    = (wptr_ff[AW] != rptr_ff[AW]) && (wptr_ff[AW-1:0] == rptr_ff[AW-1:0]);
   assign rd_data = mem_ff[rptr_ff[AW-1:0]];
   assign wptr_in = wptr_ff + {{AW{1'b0}}, 1'b1};
   assign rptr_in = rptr_ff + {{AW{1'b0}}, 1'b1};

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         if (wr_en) begin
            wptr_ff <= wptr_in;
         end
         if (rd_en) begin
            rptr_ff <= rptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wptr_ff[AW-1:0]] <= wr_data;
      end
   end

endmodule

[src/spdv_front.sv]
// Front part: takes requests, unpacks them and forms the particle separation.
module spdv_front (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [spdv_pkg::REQ_W-1:0] req_tdata,
   input  logic                     queue_full,
   output logic                     push,
   output spdv_pkg::front_type      push_data
);
   import spdv_pkg::*;

   logic signed [31:0] pos_a_x, pos_a_y, pos_b_x, pos_b_y;

   assign pos_a_x = req_tdata[31:0];
   assign pos_a_y = req_tdata[63:32];
   assign pos_b_x = req_tdata[95:64];
   assign pos_b_y = req_tdata[127:96];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_data.dx   = 33'(pos_b_x) - 33'(pos_a_x);
      push_data.dy   = 33'(pos_b_y) - 33'(pos_a_y);
      push_data.va_x = req_tdata[159:128];
      push_data.va_y = req_tdata[191:160];
      push_data.vb_x = req_tdata[223:192];
      push_data.vb_y = req_tdata[255:224];
      push_data.dt   = req_tdata[271:256];
   end

endmodule

[src/spdv_back.sv]
// Back part: the non-iterating arithmetic pipeline, square root and divider included.
module spdv_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  spdv_pkg::cfg_type           cfg,
   input  logic                        in_valid,
   input  spdv_pkg::front_type         in_data,
   output logic                        in_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [spdv_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tuser
);
   import spdv_pkg::*;

   localparam int ROOT_STEPS = 33;
   localparam int DIV_STEPS  = 47;
   localparam int S_SQ    = 0;
   localparam int S_LEN2  = 1;
   localparam int S_ROOT0 = 2;
   localparam int S_DIFF  = S_ROOT0 + ROOT_STEPS;
   localparam int S_MPROD = S_DIFF + 1;
   localparam int S_MCLIP = S_DIFF + 2;
   localparam int S_VDPP  = S_DIFF + 3;
   localparam int S_VD    = S_DIFF + 4;
   localparam int S_VADD  = S_DIFF + 5;
   localparam int S_REL   = S_DIFF + 6;
   localparam int S_TPP   = S_DIFF + 7;
   localparam int S_TSUM  = S_DIFF + 8;
   localparam int S_DM    = S_DIFF + 9;
   localparam int S_NPP   = S_DIFF + 10;
   localparam int S_NUM   = S_DIFF + 11;
   localparam int S_OVF   = S_DIFF + 12;
   localparam int S_DIV0  = S_OVF + 1;
   localparam int S_C     = S_DIV0 + DIV_STEPS;
   localparam int S_DDPP  = S_C + 1;
   localparam int S_DD    = S_C + 2;
   localparam int S_OUT   = S_C + 3;
   localparam int NST     = S_OUT + 1;

   work_type       pipe_ff [S_OUT];
   work_type       pipe_in [S_OUT];
   logic [NST-1:0] vld_ff;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic           rsp_sat_ff, rsp_sat_in;
   logic           en;

   // The whole pipeline moves unless a finished result is waiting.
   assign en         = !(vld_ff[S_OUT] && !rsp_tready);
   assign in_pop     = en && in_valid;
   assign rsp_tvalid = vld_ff[S_OUT];
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   always_comb begin
      work_type           w;
      logic [31:0]        smag;
      logic [47:0]        kp;
      logic [65:0]        sq;
      logic [35:0]        r36, trial;
      logic [34:0]        dmag;
      logic [66:0]        p67;
      logic [64:0]        p65;
      logic [47:0]        p48;
      logic [62:0]        p63;
      logic [46:0]        p47;
      logic [80:0]        s81;
      logic [47:0]        cm;
      logic signed [63:0] s64;
      logic [48:0]        cs;
      logic [110:0]       n111;
      logic [112:0]       dsh;
      logic [46:0]        mr;
      int                 i;

      // Separation magnitudes, squares and the scaled stiffness.
      w       = '0;
      w.dx    = in_data.dx;
      w.dy    = in_data.dy;
      w.neg_x = in_data.dx[32];
      w.neg_y = in_data.dy[32];
      w.mag_x = in_data.dx[32] ? 33'(-in_data.dx) : in_data.dx;
      w.mag_y = in_data.dy[32] ? 33'(-in_data.dy) : in_data.dy;
      w.va_x  = 49'(in_data.va_x);
      w.va_y  = 49'(in_data.va_y);
      w.vb_x  = 49'(in_data.vb_x);
      w.vb_y  = 49'(in_data.vb_y);
      smag    = cfg.stiffness[31] ? 32'(-cfg.stiffness) : cfg.stiffness;
      kp      = smag * in_data.dt;
      w.k_mag = kp[47:DT_BITS];
      w.k_neg = cfg.stiffness[31] && (|kp[47:DT_BITS]);
      sq      = w.mag_x * w.mag_x;
      w.pa    = {15'b0, sq};
      sq      = w.mag_y * w.mag_y;
      w.pb    = {15'b0, sq};
      pipe_in[S_SQ] = w;

      w      = pipe_ff[S_SQ];
      w.len2 = w.pa[65:0] + w.pb[65:0];
      w.nz   = |w.len2;
      w.rem  = '0;
      w.root = '0;
      pipe_in[S_LEN2] = w;

      // Restoring square root, one root bit per stage.
      for (int j = 0; j < ROOT_STEPS; j++) begin
         w      = pipe_ff[S_ROOT0 + j - 1];
         i      = ROOT_STEPS - 1 - j;
         r36    = {w.rem[33:0], w.len2[2*i +: 2]};
         trial  = {1'b0, w.root, 2'b01};
         w.root = {w.root[31:0], 1'b0};
         if (r36 >= trial) begin
            r36       = r36 - trial;
            w.root[0] = 1'b1;
         end
         w.rem = {77'b0, r36};
         pipe_in[S_ROOT0 + j] = w;
      end

      w      = pipe_ff[S_DIFF - 1];
      w.diff = $signed({2'b0, w.root}) - $signed({4'b0, cfg.rest_length});
      pipe_in[S_DIFF] = w;

      w       = pipe_ff[S_DIFF];
      dmag    = w.diff[34] ? 35'(-w.diff) : w.diff;
      p67     = w.k_mag * dmag;
      w.pa    = {14'b0, p67};
      w.m_neg = w.k_neg ^ w.diff[34];
      pipe_in[S_MPROD] = w;

      w       = pipe_ff[S_MPROD];
      s81     = w.pa >> FRAC_BITS;
      cm      = clip_mag({47'b0, s81});
      w.m_mag = cm[46:0];
      w.sat   = w.sat | cm[47];
      w.m_neg = w.m_neg && (|cm[46:0]);
      pipe_in[S_MCLIP] = w;

      w    = pipe_ff[S_MCLIP];
      p65  = w.mag_x * w.m_mag[31:0];
      w.pa = {16'b0, p65};
      p48  = w.mag_x * w.m_mag[46:32];
      w.pb = {33'b0, p48};
      p65  = w.mag_y * w.m_mag[31:0];
      w.pc = {16'b0, p65};
      p48  = w.mag_y * w.m_mag[46:32];
      w.pd = {33'b0, p48};
      pipe_in[S_VDPP] = w;

      // Hooke impulse per axis.
      w      = pipe_ff[S_VDPP];
      s81    = (w.pa + (w.pb << 32)) >> FRAC_BITS;
      cm     = clip_mag({47'b0, s81});
      w.sat  = w.sat | cm[47];
      w.vd_x = (w.neg_x ^ w.m_neg) ? -{1'b0, cm[46:0]} : {1'b0, cm[46:0]};
      s81    = (w.pc + (w.pd << 32)) >> FRAC_BITS;
      cm     = clip_mag({47'b0, s81});
      w.sat  = w.sat | cm[47];
      w.vd_y = (w.neg_y ^ w.m_neg) ? -{1'b0, cm[46:0]} : {1'b0, cm[46:0]};
      pipe_in[S_VD] = w;

      w      = pipe_ff[S_VD];
      s64    = 64'(w.va_x) + 64'(w.vd_x);
      cs     = clip_sgn(s64);
      w.va_x = {cs[47], cs[47:0]};
      w.sat  = w.sat | cs[48];
      s64    = 64'(w.va_y) + 64'(w.vd_y);
      cs     = clip_sgn(s64);
      w.va_y = {cs[47], cs[47:0]};
      w.sat  = w.sat | cs[48];
      s64    = 64'(w.vb_x) - 64'(w.vd_x);
      cs     = clip_sgn(s64);
      w.vb_x = {cs[47], cs[47:0]};
      w.sat  = w.sat | cs[48];
      s64    = 64'(w.vb_y) - 64'(w.vd_y);
      cs     = clip_sgn(s64);
      w.vb_y = {cs[47], cs[47:0]};
      w.sat  = w.sat | cs[48];
      pipe_in[S_VADD] = w;

      // Relative velocity; its clipping only counts when damping applies.
      w     = pipe_ff[S_VADD];
      s64   = 64'(w.va_x) - 64'(w.vb_x);
      cs    = clip_sgn(s64);
      w.rx  = cs[47:0];
      w.sat = w.sat | (cs[48] & w.nz);
      s64   = 64'(w.va_y) - 64'(w.vb_y);
      cs    = clip_sgn(s64);
      w.ry  = cs[47:0];
      w.sat = w.sat | (cs[48] & w.nz);
      pipe_in[S_REL] = w;

      w    = pipe_ff[S_REL];
      mr   = w.rx[47] ? 47'(-w.rx) : w.rx[46:0];
      p65  = mr[31:0] * w.mag_x;
      w.pa = {16'b0, p65};
      p48  = mr[46:32] * w.mag_x;
      w.pb = {33'b0, p48};
      w.n1 = w.rx[47] ^ w.neg_x;
      mr   = w.ry[47] ? 47'(-w.ry) : w.ry[46:0];
      p65  = mr[31:0] * w.mag_y;
      w.pc = {16'b0, p65};
      p48  = mr[46:32] * w.mag_y;
      w.pd = {33'b0, p48};
      w.n2 = w.ry[47] ^ w.neg_y;
      pipe_in[S_TPP] = w;

      w    = pipe_ff[S_TPP];
      w.t1 = w.pa[79:0] + (w.pb[79:0] << 32);
      w.t2 = w.pc[79:0] + (w.pd[79:0] << 32);
      pipe_in[S_TSUM] = w;

      // Signed dot product of relative velocity and separation.
      w = pipe_ff[S_TSUM];
      if (w.n1 == w.n2) begin
         w.dm   = w.t1 + w.t2;
         w.dneg = w.n1;
      end else if (w.t1 >= w.t2) begin
         w.dm   = w.t1 - w.t2;
         w.dneg = w.n1;
      end else begin
         w.dm   = w.t2 - w.t1;
         w.dneg = w.n2;
      end
      pipe_in[S_DM] = w;

      w    = pipe_ff[S_DM];
      p63  = w.dm[31:0] * cfg.damping_gain;
      w.pa = {18'b0, p63};
      p63  = w.dm[63:32] * cfg.damping_gain;
      w.pb = {18'b0, p63};
      p47  = w.dm[79:64] * cfg.damping_gain;
      w.pc = {34'b0, p47};
      pipe_in[S_NPP] = w;

      w     = pipe_ff[S_NPP];
      n111  = {48'b0, w.pa[62:0]} + ({48'b0, w.pb[62:0]} << 32)
            + ({64'b0, w.pc[46:0]} << 64);
      w.num = n111;
      pipe_in[S_NUM] = w;

      // A quotient of 2^47 or more is clipped, so only 47 quotient bits are formed.
      w     = pipe_ff[S_NUM];
      w.ovf = ({2'b0, w.num} >= {w.len2, 47'b0});
      w.rem = {2'b0, w.num};
      w.quo = '0;
      pipe_in[S_OVF] = w;

      for (int j = 0; j < DIV_STEPS; j++) begin
         w   = pipe_ff[S_DIV0 + j - 1];
         i   = DIV_STEPS - 1 - j;
         dsh = {47'b0, w.len2} << i;
         if (w.rem >= dsh) begin
            w.rem    = w.rem - dsh;
            w.quo[i] = 1'b1;
         end
         pipe_in[S_DIV0 + j] = w;
      end

      w       = pipe_ff[S_C - 1];
      w.c_mag = w.ovf ? LIM : w.quo;
      w.sat   = w.sat | (w.ovf & w.nz);
      w.c_neg = w.dneg && (|w.c_mag);
      pipe_in[S_C] = w;

      w    = pipe_ff[S_C];
      p65  = w.mag_x * w.c_mag[31:0];
      w.pa = {16'b0, p65};
      p48  = w.mag_x * w.c_mag[46:32];
      w.pb = {33'b0, p48};
      p65  = w.mag_y * w.c_mag[31:0];
      w.pc = {16'b0, p65};
      p48  = w.mag_y * w.c_mag[46:32];
      w.pd = {33'b0, p48};
      pipe_in[S_DDPP] = w;

      // Damping transfer per axis, kept in the impulse fields.
      w      = pipe_ff[S_DDPP];
      s81    = (w.pa + (w.pb << 32)) >> FRAC_BITS;
      cm     = clip_mag({47'b0, s81});
      w.sat  = w.sat | (cm[47] & w.nz);
      w.vd_x = (w.neg_x ^ w.c_neg) ? -{1'b0, cm[46:0]} : {1'b0, cm[46:0]};
      s81    = (w.pc + (w.pd << 32)) >> FRAC_BITS;
      cm     = clip_mag({47'b0, s81});
      w.sat  = w.sat | (cm[47] & w.nz);
      w.vd_y = (w.neg_y ^ w.c_neg) ? -{1'b0, cm[46:0]} : {1'b0, cm[46:0]};
      pipe_in[S_DD] = w;
   end

   always_comb begin
      work_type           w;
      logic signed [63:0] s64;
      logic [32:0]        co;
      logic               sat;

      w   = pipe_ff[S_DD];
      sat = w.sat;
      s64 = w.nz ? (64'(w.va_x) - 64'(w.vd_x)) : 64'(w.va_x);
      co  = clip_out(s64);
      rsp_data_in[31:0] = co[31:0];
      sat = sat | co[32];
      s64 = w.nz ? (64'(w.va_y) - 64'(w.vd_y)) : 64'(w.va_y);
      co  = clip_out(s64);
      rsp_data_in[63:32] = co[31:0];
      sat = sat | co[32];
      s64 = w.nz ? (64'(w.vb_x) + 64'(w.vd_x)) : 64'(w.vb_x);
      co  = clip_out(s64);
      rsp_data_in[95:64] = co[31:0];
      sat = sat | co[32];
      s64 = w.nz ? (64'(w.vb_y) + 64'(w.vd_y)) : 64'(w.vb_y);
      co  = clip_out(s64);
      rsp_data_in[127:96] = co[31:0];
      sat = sat | co[32];
      rsp_sat_in = sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff     <= pipe_in;
         rsp_data_ff <= rsp_data_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

`ifndef ASSERT_OFF
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved while stalled");
   a_entry_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(vld_ff[S_SQ]) |-> $past(in_valid))
      else $error("pipeline entry without a queued request");
   a_out_refill: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> (rsp_tvalid == $past(vld_ff[S_DD])))
      else $error("output register not refilled from the last stage");
`endif

endmodule

[tb/spdv_checker.sv]
`timescale 1ns / 100ps
// Watches the request and response streams, predicts each velocity update and compares it.
module spdv_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [spdv_pkg::REQ_W-1:0]      req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [spdv_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic [spdv_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [31:0]                     csr_wdata,
   output int                              mismatches,
   output int                              outstanding,
   output int                              updates_seen,
   output int                              clipped_seen
);
   import spdv_pkg::*;

   localparam logic signed [63:0] LIM47 = 64'sh0000_7FFF_FFFF_FFFF;

   typedef struct packed {
      logic [31:0] va_x;
      logic [31:0] va_y;
      logic [31:0] vb_x;
      logic [31:0] vb_y;
      logic        sat;
   } vel_update_type;

   logic signed [63:0] stiff_sh;
   logic [30:0]        rest_sh;
   logic [30:0]        gain_sh;
   vel_update_type     pending_updates[$];

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic signed [63:0] clip_mag47(input logic [127:0] m, input logic neg,
                                                     inout logic sat);
      logic signed [63:0] r;
      if (m > {64'b0, LIM47}) begin
         sat = 1'b1;
         r = LIM47;
      end else begin
         r = m[63:0];
      end
      return neg ? -r : r;
   endfunction

   function automatic logic signed [63:0] clip_sgn47(input logic signed [63:0] v,
                                                     inout logic sat);
      if (v > LIM47) begin
         sat = 1'b1;
         return LIM47;
      end
      if (v < -LIM47) begin
         sat = 1'b1;
         return -LIM47;
      end
      return v;
   endfunction

   function automatic logic [31:0] clip_out32(input logic signed [63:0] v, inout logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // Signed product scaled down by 2^sh, truncated toward zero, clipped to 48 bits.
   function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int sh, inout logic sat);
      logic [127:0] p;
      p = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
      return clip_mag47(p >> sh, (a < 0) != (b < 0), sat);
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
      logic [63:0]  root;
      logic [63:0]  trial;
      root = '0;
      for (int i = 63; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if ({64'b0, trial} * {64'b0, trial} <= v) root = trial;
      end
      return root;
   endfunction

   function automatic vel_update_type predict_update(input logic [REQ_W-1:0] d);
      logic signed [63:0] dx, dy, vax, vay, vbx, vby, dt, len, k, m, vdx, vdy;
      logic signed [63:0] rx, ry, c, ddx, ddy;
      logic [127:0]       len2, t1, t2, dm, num;
      logic               n1, n2, dneg, sat;
      vel_update_type     res;
      sat = 1'b0;
      dx  = 64'($signed(d[95:64]))  - 64'($signed(d[31:0]));
      dy  = 64'($signed(d[127:96])) - 64'($signed(d[63:32]));
      vax = 64'($signed(d[159:128]));
      vay = 64'($signed(d[191:160]));
      vbx = 64'($signed(d[223:192]));
      vby = 64'($signed(d[255:224]));
      dt  = {48'b0, d[271:256]};
      len2 = {64'b0, magnitude(dx)} * {64'b0, magnitude(dx)}
           + {64'b0, magnitude(dy)} * {64'b0, magnitude(dy)};
      len = floor_sqrt(len2);
      k   = scaled_product(stiff_sh, dt, DT_BITS, sat);
      m   = scaled_product(k, len - {33'b0, rest_sh}, FRAC_BITS, sat);
      vdx = scaled_product(dx, m, FRAC_BITS, sat);
      vdy = scaled_product(dy, m, FRAC_BITS, sat);
      vax = clip_sgn47(vax + vdx, sat);
      vay = clip_sgn47(vay + vdy, sat);
      vbx = clip_sgn47(vbx - vdx, sat);
      vby = clip_sgn47(vby - vdy, sat);
      // Damping is skipped when the two particles coincide.
      if (len2 != 0) begin
         rx = clip_sgn47(vax - vbx, sat);
         ry = clip_sgn47(vay - vby, sat);
         t1 = {64'b0, magnitude(rx)} * {64'b0, magnitude(dx)};
         t2 = {64'b0, magnitude(ry)} * {64'b0, magnitude(dy)};
         n1 = (rx < 0) != (dx < 0);
         n2 = (ry < 0) != (dy < 0);
         if (n1 == n2) begin
            dm = t1 + t2;
            dneg = n1;
         end else if (t1 >= t2) begin
            dm = t1 - t2;
            dneg = n1;
         end else begin
            dm = t2 - t1;
            dneg = n2;
         end
         num = dm * {97'b0, gain_sh};
         c   = clip_mag47(num / len2, dneg, sat);
         ddx = scaled_product(dx, c, FRAC_BITS, sat);
         ddy = scaled_product(dy, c, FRAC_BITS, sat);
         vax = vax - ddx;
         vay = vay - ddy;
         vbx = vbx + ddx;
         vby = vby + ddy;
      end
      res.va_x = clip_out32(vax, sat);
      res.va_y = clip_out32(vay, sat);
      res.vb_x = clip_out32(vbx, sat);
      res.vb_y = clip_out32(vby, sat);
      res.sat  = sat;
      return res;
   endfunction

   always @(posedge clock) begin
      vel_update_type want;
      vel_update_type got;
      if (reset) begin
         stiff_sh <= 64'sd65536;
         rest_sh  <= 31'd65536;
         gain_sh  <= 31'd32768;
         pending_updates.delete();
         mismatches   <= 0;
         outstanding  <= 0;
         updates_seen <= 0;
         clipped_seen <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_STIFFNESS: begin
                  stiff_sh <= 64'($signed(csr_wdata));
               end
               CSR_REST_LENGTH: begin
                  rest_sh <= csr_wdata[30:0];
               end
               CSR_DAMPING_GAIN: begin
                  gain_sh <= csr_wdata[30:0];
               end
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) pending_updates.push_back(predict_update(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tdata[127:96],
                   rsp_tuser};
            updates_seen <= updates_seen + 1;
            if (rsp_tuser) clipped_seen <= clipped_seen + 1;
            if (pending_updates.size() == 0) begin
               if (mismatches < 10) $display("ERROR: response with no request waiting: %h", got);
               mismatches <= mismatches + 1;
            end else begin
               want = pending_updates.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("ERROR: velocity mismatch at %0t", $realtime);
                     $display("   expected a=(%h,%h) b=(%h,%h) sat=%b",
                              want.va_x, want.va_y, want.vb_x, want.vb_y, want.sat);
                     $display("   actual   a=(%h,%h) b=(%h,%h) sat=%b",
                              got.va_x, got.va_y, got.vb_x, got.vb_y, got.sat);
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end
         outstanding <= pending_updates.size();
      end
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Top of the spring-damper velocity update testbench: clock, reset, stimulus and verdict.
module tb;
   import spdv_pkg::*;

   localparam int FRAC_BITS = 16;
   // Index three holds no register; writes to it must be ignored.
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 5000;
   localparam int ITEMS_PER_SETTING = 76;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y, time_step
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
   logic [RSP_W-1:0]      rsp_tdata;
   // saturated
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [31:0]           csr_wdata = '0;

   int  mismatches, outstanding, updates_seen, clipped_seen;
   int  requests_sent = 0;
   int  idle_cycles = 0;
   bit  steady = 1'b0;      // no sender gaps while set
   bit  hold_receiver = 1'b0;

   always #5 clock = ~clock;

   spring_damper_velocity_update #(.FRAC_BITS(FRAC_BITS)) dut (.*);

   spdv_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);

   // The watchdog ends the run if neither stream moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no traffic for %0d cycles", IDLE_LIMIT);
         $display("spring_damper_velocity_update verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The receiver mostly takes responses, sometimes pauses briefly and now and
   // then for a long while. On request it holds off for a long stretch so that
   // the pipeline and queue fill and the block stops taking requests.
   initial begin
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_receiver) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_receiver = 1'b0;
         end else begin
            hold = $urandom_range(0, 99);
            if (hold < 70 || steady) begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(1, 20)) @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               if (hold < 96) repeat ($urandom_range(1, 4)) @(posedge clock);
               else repeat ($urandom_range(20, 80)) @(posedge clock);
            end
         end
      end
   end

   function automatic logic [REQ_W-1:0] pack_request(
         input logic [31:0] pax, input logic [31:0] pay, input logic [31:0] pbx,
         input logic [31:0] pby, input logic [31:0] vax, input logic [31:0] vay,
         input logic [31:0] vbx, input logic [31:0] vby, input logic [15:0] dt);
      return {dt, vby, vbx, vay, vax, pby, pbx, pay, pax};
   endfunction

   // A field value: mostly small magnitudes so the spring works in its normal
   // range, with some fully random words and some extremes.
   function automatic logic [31:0] field_value(input logic [31:0] centre);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return centre + 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      if (pick < 9) return $urandom;
      return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
   endfunction

   function automatic logic [REQ_W-1:0] random_request();
      logic [31:0] ax, ay;
      ax = field_value(32'd0);
      ay = field_value(32'd0);
      return pack_request(ax, ay, field_value(ax), field_value(ay),
                          field_value(32'd0), field_value(32'd0),
                          field_value(32'd0), field_value(32'd0),
                          16'($urandom));
   endfunction

   // Offers one request and returns once it has been taken. The valid stays
   // high between back-to-back requests; gaps lower it first.
   task automatic offer(input logic [REQ_W-1:0] data);
      int pick;
      bit hit;
      pick = $urandom_range(0, 99);
      if (!steady && pick >= 65) begin
         req_tvalid <= 1'b0;
         if (pick < 96) repeat ($urandom_range(1, 3)) @(posedge clock);
         else repeat ($urandom_range(15, 60)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do begin
         @(negedge clock);
         hit = req_tready;
         @(posedge clock);
      end while (!hit);
      requests_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Registers are written back to back while the block is idle.
   task automatic write_settings(input logic [31:0] stiff, input logic [31:0] rest,
                                 input logic [31:0] gain);
      csr_we <= 1'b1;
      csr_addr <= CSR_STIFFNESS;
      csr_wdata <= stiff;
      @(posedge clock);
      csr_addr <= CSR_REST_LENGTH;
      csr_wdata <= rest;
      @(posedge clock);
      csr_addr <= CSR_DAMPING_GAIN;
      csr_wdata <= gain;
      @(posedge clock);
      csr_addr <= CSR_UNUSED;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_batch(input int count);
      for (int i = 0; i < count; i++) begin
         steady = (i >= count / 2) && (i < count / 2 + 15);
         offer(random_request());
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under the reset settings.
      offer(pack_request('0, '0, '0, '0, '0, '0, '0, '0, '0));
      // Coincident particles with moving velocities: no damping term.
      offer(pack_request(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000,
                         32'h0003_0000, 32'hFFFE_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         16'hFFFF));
      // Separation exactly at the rest length: no spring impulse.
      offer(pack_request('0, '0, 32'h0001_0000, '0, 32'h0002_0000, '0, '0, 32'h0001_0000,
                         16'h8000));
      // Widest separations, both signs on each axis.
      offer(pack_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                         '0, '0, '0, '0, 16'hFFFF));
      offer(pack_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                         16'h0001));
      // All ones everywhere, then the most negative words with a zero time step.
      offer(pack_request('1, '1, '1, '1, '1, '1, '1, '1, '1));
      offer(pack_request({32{1'b1}} << 31, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0));
      // Zero time step with a stretched spring: damping only.
      offer(pack_request('0, '0, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000,
                         32'hFFFF_8000, 32'hFFFE_0000, 32'h0000_4000, 16'h0000));
      // Separation along one axis only: first tiny, then wide and negative.
      offer(pack_request(32'h0000_0005, '0, 32'h0000_0006, '0, 32'h1000_0000, '0,
                         32'hF000_0000, '0, 16'h1234));
      offer(pack_request('0, 32'h0010_0000, '0, 32'hFFF0_0000, '0, 32'h7000_0000,
                         '0, 32'h9000_0000, 16'hFFFF));
      random_batch(ITEMS_PER_SETTING - 10);
      drain();

      // Strongest positive spring, short rest length, no damping.
      write_settings(32'h7FFF_FFFF, 32'd7, 32'd0);
      offer(pack_request('0, '0, 32'h0000_0001, '0, '0, '0, '0, '0, 16'hFFFF));
      random_batch(ITEMS_PER_SETTING - 1);
      drain();

      // Most negative spring, longest rest length, largest damping. The
      // receiver holds off while requests keep coming.
      write_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      hold_receiver = 1'b1;
      steady = 1'b1;
      for (int i = 0; i < 150; i++) offer(random_request());
      steady = 1'b0;
      drain();

      // Rest length written with bit 31 set; bit 31 of the written word is dropped
      // and the remaining value of one is used as given.
      write_settings(32'hFFFF_8000, 32'h8000_0001, 32'h0001_0000);
      random_batch(ITEMS_PER_SETTING / 2);
      drain();

      write_settings($urandom, $urandom, $urandom);
      random_batch(ITEMS_PER_SETTING / 2);
      drain();

      write_settings(32'h0004_0000, 32'h0002_0000, 32'h0000_2000);
      random_batch(ITEMS_PER_SETTING);
      drain();

      repeat (120) @(posedge clock);
      $display("Ran %0d requests over six register settings, %0d responses checked,",
               requests_sent, updates_seen);
      $display("%0d of them clipped, with back-pressure and a long receiver hold.",
               clipped_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("spring_damper_velocity_update verification clean");
      end else begin
         $display("spring_damper_velocity_update verification failed");
      end
      $finish;
   end

endmodule

[files.f]
src/spdv_pkg.sv
src/spdv_fifo.sv
src/spdv_front.sv
src/spdv_back.sv
src/spring_damper_velocity_update.sv
tb/spdv_checker.sv
tb/tb.sv
